// ===== src/aumbs_pkg.sv =====
`default_nettype none

package aumbs_pkg;

	localparam logic [3:0] OffsetMax      = 4'd15;
	localparam logic [3:0] HighPassNibble = 4'h9;
	localparam logic [3:0] RingLen        = 4'd15;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// Run length that belongs to each low nibble of the pattern key.
	function automatic logic [3:0] run_len(input logic [3:0] lo);
		logic [3:0] r;
		begin
			case (lo)
				4'd0: r = 4'd0;
				4'd1: r = 4'd1;
				4'd2: r = 4'd3;
				4'd3: r = 4'd5;
				4'd4: r = 4'd7;
				4'd5: r = 4'd9;
				4'd6: r = 4'd11;
				4'd7: r = 4'd13;
				4'd8: r = 4'd14;
				4'd9: r = 4'd12;
				4'd10: r = 4'd10;
				4'd11: r = 4'd8;
				4'd12: r = 4'd6;
				4'd13: r = 4'd4;
				4'd14: r = 4'd2;
				default: r = 4'd0;
			endcase
			return r;
		end
	endfunction

	// Interleaved low-nibble sequence.
	function automatic logic [3:0] lo_nib(input logic [3:0] idx);
		logic [3:0] r;
		begin
			case (idx)
				4'd0: r = 4'h8;
				4'd1: r = 4'h7;
				4'd2: r = 4'h9;
				4'd3: r = 4'h6;
				4'd4: r = 4'ha;
				4'd5: r = 4'h5;
				4'd6: r = 4'hb;
				4'd7: r = 4'h4;
				4'd8: r = 4'hc;
				4'd9: r = 4'h3;
				4'd10: r = 4'hd;
				4'd11: r = 4'h2;
				4'd12: r = 4'he;
				4'd13: r = 4'h1;
				default: r = 4'hf;
			endcase
			return r;
		end
	endfunction

	// Circular high-nibble sequence of fifteen entries.
	function automatic logic [3:0] hi_ring(input logic [3:0] idx);
		logic [3:0] r;
		begin
			case (idx)
				4'd0: r = 4'h0;
				4'd1: r = 4'h6;
				4'd2: r = 4'hf;
				4'd3: r = 4'h8;
				4'd4: r = 4'h7;
				4'd5: r = 4'h5;
				4'd6: r = 4'h3;
				4'd7: r = 4'h4;
				4'd8: r = 4'hc;
				4'd9: r = 4'hd;
				4'd10: r = 4'he;
				4'd11: r = 4'h1;
				4'd12: r = 4'h2;
				4'd13: r = 4'hb;
				default: r = 4'ha;
			endcase
			return r;
		end
	endfunction

	// Starting place in the ring for each high nibble of the key.
	function automatic logic [3:0] hi_start(input logic [3:0] hi);
		logic [3:0] r;
		begin
			case (hi)
				4'd0: r = 4'd0;
				4'd1: r = 4'd11;
				4'd2: r = 4'd12;
				4'd3: r = 4'd6;
				4'd4: r = 4'd7;
				4'd5: r = 4'd5;
				4'd6: r = 4'd1;
				4'd7: r = 4'd4;
				4'd8: r = 4'd3;
				4'd9: r = 4'd0;
				4'd10: r = 4'd14;
				4'd11: r = 4'd13;
				4'd12: r = 4'd8;
				4'd13: r = 4'd9;
				4'd14: r = 4'd10;
				default: r = 4'd2;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// ===== src/aumbs_salt_lut.sv =====
`default_nettype none

module aumbs_salt_lut
	import aumbs_pkg::*;
(
	input  wire logic [7:0] key,
	input  wire logic [3:0] pos,
	output logic      [7:0] salt
);

	logic [3:0] lo;
	logic [3:0] hi;
	logic [3:0] rl;
	logic [4:0] ring_sum;
	logic [3:0] ring_idx;
	logic [3:0] hr;
	logic [4:0] li_sum;
	logic [3:0] li;

	always_comb begin
		lo = key[3:0];
		hi = key[7:4];
		rl = run_len(lo);

		ring_sum = {1'b0, hi_start(hi)} + {1'b0, pos};
		if (ring_sum >= {1'b0, RingLen})
			ring_sum = ring_sum - {1'b0, RingLen};
		ring_idx = ring_sum[3:0];
		hr = (hi == HighPassNibble) ? HighPassNibble : hi_ring(ring_idx);

		// The index stays at or below fourteen whenever the run still covers pos.
		li_sum = 5'd14 - {1'b0, rl} + {1'b0, pos};
		li = (li_sum > 5'd14) ? 4'd14 : li_sum[3:0];

		if (pos == 4'd0)
			salt = key;
		else if (rl < pos)
			salt = 8'h00;
		else
			salt = {hr, lo_nib(li)};
	end

endmodule

`default_nettype wire

// ===== src/audio_magic_byte_scrambler.sv =====
// Channel  Handshake                 Payload
// in       in_valid / in_stall       magic_byte, last_in_frame
// out      out_valid / out_stall     result_byte
// cfg      cfg_valid / cfg_ready     decode_mode
//
// One byte enters per cycle while in_stall is low; it passes the input
// register, then the result register, and leaves when out_stall is low. The
// carried salt, key and offset update in the cycle that moves a byte to the
// result register. Reset clears the valid flags, salt, key and offset and
// selects encode. A stalled output holds the result, then the input register.
`default_nettype none

module audio_magic_byte_scrambler
	import aumbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] magic_byte,
	input  wire logic       last_in_frame,

	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [7:0] result_byte,

	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       decode_mode
);

	logic       mode_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic [7:0] result_q;

	logic [7:0] salt_q;
	logic [7:0] key_q;
	logic [3:0] offset_q;

	logic       advance;
	logic       take_in;
	logic [7:0] res;
	logic       restart;
	logic [3:0] pos_base;
	logic [3:0] pos_next;
	logic [7:0] key_next;
	logic [7:0] salt_next;

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign result_byte = result_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_comb begin
		res = byte_s1 ^ salt_q;
		if (mode_q == MODE_DECODE)
			restart = (res != 8'h00);
		else
			restart = (byte_s1 != 8'h00) || (offset_q == 4'd0);
		pos_base = restart ? 4'd0 : offset_q;
		if (restart)
			key_next = (mode_q == MODE_DECODE) ? byte_s1 : res;
		else
			key_next = key_q;
		pos_next = (pos_base < OffsetMax) ? pos_base + 4'd1 : OffsetMax;
	end

	aumbs_salt_lut u_salt (
		.key  (key_next),
		.pos  (pos_next),
		.salt (salt_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= decode_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= magic_byte;
			last_s1 <= last_in_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	// The frame's last channel drops the run so the next frame starts clean.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q   <= 8'h00;
			key_q    <= 8'h00;
			offset_q <= 4'd0;
		end else if (advance) begin
			if (last_s1) begin
				salt_q   <= 8'h00;
				key_q    <= 8'h00;
				offset_q <= 4'd0;
			end else begin
				salt_q   <= salt_next;
				key_q    <= key_next;
				offset_q <= pos_next;
			end
		end
	end

	a_frame_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> salt_q == 8'h00 && key_q == 8'h00 && offset_q == 4'd0)
		else $error("state not cleared after last channel of frame");

	a_saturated_salt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q == OffsetMax |-> salt_q == 8'h00)
		else $error("nonzero salt at saturated run offset");

	a_result_follows_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && result_q == $past(res))
		else $error("result register missed a transfer");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked output");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import aumbs_pkg::*;

	localparam int RANDOM_PHASES    = 6;
	localparam int BYTES_PER_PHASE  = 175;
	localparam int MAX_IDLE         = 14;
	localparam int MAX_SHOWN_ERRORS = 50;

	// Nibble tables of the salt recurrence, entry 0 leftmost.
	localparam logic [0:15][3:0] RUN_LEN = {4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13,
		4'd14, 4'd12, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2, 4'd0};
	localparam logic [0:14][3:0] LO_SEQ = {4'h8, 4'h7, 4'h9, 4'h6, 4'ha, 4'h5, 4'hb, 4'h4,
		4'hc, 4'h3, 4'hd, 4'h2, 4'he, 4'h1, 4'hf};
	localparam logic [0:14][3:0] HI_RING = {4'h0, 4'h6, 4'hf, 4'h8, 4'h7, 4'h5, 4'h3, 4'h4,
		4'hc, 4'hd, 4'he, 4'h1, 4'h2, 4'hb, 4'ha};
	localparam logic [0:15][3:0] HI_START = {4'd0, 4'd11, 4'd12, 4'd6, 4'd7, 4'd5, 4'd1, 4'd4,
		4'd3, 4'd0, 4'd14, 4'd13, 4'd8, 4'd9, 4'd10, 4'd2};

	typedef struct packed {
		logic       mode;
		logic [7:0] chan_byte;
		logic       last;
		logic [4:0] reps;
		logic       typed;
		logic [7:0] typed_byte;
	} chan_row_t;

	localparam int DIRECTED_ROWS = 12;

	chan_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{MODE_ENCODE, 8'h00, 1'b0, 5'd1,  1'b1, 8'h00},
		'{MODE_ENCODE, 8'hff, 1'b1, 5'd1,  1'b1, 8'hff},
		'{MODE_ENCODE, 8'h98, 1'b0, 5'd1,  1'b1, 8'h98},
		'{MODE_ENCODE, 8'h00, 1'b0, 5'd14, 1'b0, 8'h00},
		'{MODE_ENCODE, 8'h00, 1'b1, 5'd1,  1'b1, 8'h00},
		'{MODE_ENCODE, 8'h5a, 1'b0, 5'd1,  1'b1, 8'h5a},
		'{MODE_DECODE, 8'h00, 1'b0, 5'd1,  1'b0, 8'h00},
		'{MODE_DECODE, 8'hff, 1'b1, 5'd1,  1'b0, 8'h00},
		'{MODE_DECODE, 8'h00, 1'b0, 5'd1,  1'b1, 8'h00},
		'{MODE_DECODE, 8'h80, 1'b0, 5'd1,  1'b0, 8'h00},
		'{MODE_DECODE, 8'h37, 1'b1, 5'd1,  1'b0, 8'h00},
		'{MODE_ENCODE, 8'h00, 1'b1, 5'd1,  1'b1, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] magic_byte = 8'h00;
	logic       last_in_frame = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] result_byte;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       mode_data = 1'b0;

	// Predicted scrambler state, advanced at every input transfer.
	logic       mode_r = MODE_ENCODE;
	logic [7:0] salt_r = 8'h00;
	logic [7:0] key_r = 8'h00;
	logic [3:0] offset_r = 4'd0;

	logic [7:0] expected_bytes [$];
	logic [7:0] want_byte;
	logic       in_quiet = 1'b0;
	logic       out_quiet = 1'b0;
	int         errors = 0;
	int         bytes_sent = 0;
	int         frames_sent = 0;
	int         results_checked = 0;
	int         mode_writes = 0;

	audio_magic_byte_scrambler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.magic_byte   (magic_byte),
		.last_in_frame(last_in_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_byte  (result_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.decode_mode  (mode_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] salt_for(input logic [7:0] key, input logic [3:0] pos);
		int         rl;
		int         li;
		logic [3:0] hr;
		rl = RUN_LEN[key[3:0]];
		if (rl < pos)
			return 8'h00;
		if (key[7:4] == HighPassNibble)
			hr = HighPassNibble;
		else
			hr = HI_RING[(HI_START[key[7:4]] + pos) % 15];
		li = 14 - rl + pos;
		if (li > 14)
			li = 14;
		return {hr, LO_SEQ[li]};
	endfunction

	task automatic advance_scrambler(input logic [7:0] b, input logic lst, output logic [7:0] res);
		logic [3:0] pos;
		res = b ^ salt_r;
		pos = offset_r;
		if (mode_r == MODE_ENCODE) begin
			if (b != 8'h00)
				pos = 4'd0;
			if (pos == 4'd0)
				key_r = res;
		end else if (res != 8'h00) begin
			pos = 4'd0;
			key_r = b;
		end
		if (pos < OffsetMax)
			pos = pos + 4'd1;
		offset_r = pos;
		salt_r = salt_for(key_r, pos);
		if (lst) begin
			salt_r = 8'h00;
			key_r = 8'h00;
			offset_r = 4'd0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
			input logic [7:0] typed_val);
		int         gap;
		logic [7:0] res;
		gap = in_quiet ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		magic_byte <= b;
		last_in_frame <= lst;
		do @(posedge clk); while (in_stall !== 1'b0);
		advance_scrambler(b, lst, res);
		expected_bytes.push_back(typed ? typed_val : res);
		bytes_sent++;
		if (lst)
			frames_sent++;
	endtask

	// Waits on the clock before checking the queue, so the lowered valid never shares a step with another drive.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_bytes.size() != 0);
	endtask

	task automatic write_mode(input logic m);
		cfg_valid <= 1'b1;
		mode_data <= m;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		mode_r = m;
		mode_writes++;
	endtask

	// Output side: a random stall before each transfer, none in quiet phases.
	initial begin
		int n;
		wait (arst_n === 1'b1);
		forever begin
			n = out_quiet ? 0 : $urandom_range(0, MAX_IDLE);
			out_stall <= (n != 0);
			if (n != 0) begin
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_bytes.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN_ERRORS)
					$display("%0t: unexpected result, expected none, actual %02h", $time,
						result_byte);
			end else begin
				want_byte = expected_bytes.pop_front();
				results_checked++;
				if (result_byte !== want_byte) begin
					errors++;
					if (errors <= MAX_SHOWN_ERRORS)
						$display("%0t: result_byte mismatch, expected %02h, actual %02h",
							$time, want_byte, result_byte);
				end
			end
		end
	end

	initial begin
		int         frame_left;
		int         sel;
		logic [7:0] b;
		frame_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].mode != mode_r) begin
				wait_drained();
				write_mode(directed_rows[r].mode);
			end
			repeat (directed_rows[r].reps)
				send_byte(directed_rows[r].chan_byte, directed_rows[r].last,
					directed_rows[r].typed, directed_rows[r].typed_byte);
		end

		// Frames run across phase boundaries, so some mode writes land mid-frame.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			if (p == 0)
				write_mode(MODE_DECODE);
			else if (p == 1)
				write_mode(MODE_ENCODE);
			else
				write_mode($urandom_range(0, 1) == 0 ? MODE_ENCODE : MODE_DECODE);
			in_quiet = (p == 2) || (p == 4);
			out_quiet = (p == 3) || (p == 4);
			for (int i = 0; i < BYTES_PER_PHASE; i++) begin
				if (frame_left == 0)
					frame_left = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) :
						$urandom_range(1, 12);
				sel = $urandom_range(0, 99);
				// A plain zero keeps a run going; in decode that is the current salt.
				if (sel < 55)
					b = (mode_r == MODE_ENCODE) ? 8'h00 : salt_r;
				else if (sel < 62)
					b = {HighPassNibble, 4'($urandom_range(0, 15))};
				else if (sel < 66)
					b = 8'hff;
				else
					b = 8'($urandom_range(0, 255));
				frame_left--;
				send_byte(b, frame_left == 0, 1'b0, 8'h00);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived, expected %02h first, actual none",
				$time, expected_bytes.size(), expected_bytes[0]);
		end
		$display("Checked %0d result bytes for %0d channel bytes in %0d frames.",
			results_checked, bytes_sent, frames_sent);
		$display("Mode register written %0d times, with runs, saturation and random stalls.",
			mode_writes);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/aumbs_pkg.sv
src/aumbs_salt_lut.sv
src/audio_magic_byte_scrambler.sv
tb/sv/tb_top.sv
